// File: sv/upe_pkg.sv
// Shared types and constants for the UTF-8 percent escaper.
// Used by utf8_percent_escape and its port checker; depends on nothing.
`default_nettype none

package upe_pkg;

	// Output characters with a fixed meaning
	localparam logic [7:0] PCT_CHAR = 8'h25;   // '%'
	localparam logic [7:0] ERR_CHAR = 8'h00;   // character sent with the error flag

	// Code point range of a high surrogate
	localparam logic [20:0] SURR_LO = 21'h00D800;
	localparam logic [20:0] SURR_HI = 21'h00DBFF;
	localparam logic [20:0] SUPP_BASE = 21'h010000;

	// One string step decodes at most this many code points, each giving
	// at most four escaped bytes
	localparam int CP_SLOTS = 3;
	localparam int UNITS_PER_CP = 4;

	// Decoded code point (four-byte forms reach 21 bits)
	typedef logic [20:0] cp_t;

	// One output unit: a literal character or a byte sent as %XX
	typedef struct packed {
		logic       pct;
		logic [7:0] val;
	} unit_t;

	// Units produced by one code point
	typedef struct packed {
		logic [2:0]                   cnt;
		logic                         surr;
		unit_t [UNITS_PER_CP-1:0]     u;
	} cp_units_t;

	// Upper-case hex digit for a nibble
	function automatic logic [7:0] hex_char(logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'b0, n}) : (8'h37 + {4'b0, n});
	endfunction

endpackage

`default_nettype wire

// File: sv/utf8_percent_escape.sv
// Top level of the UTF-8 percent escaper: decode, escape and serialise.
// Depends on upe_pkg for unit types, hex digits and code point limits.
//
// Usage:
//   Slave side (in_*) takes one byte of a UTF-8 string per beat, with
//   in_tlast on the final byte. Master side (out_*) gives the escaped
//   text one ASCII character per beat, out_tlast on the final character
//   of the string, out_tuser set on a single error beat (character 0)
//   when a high surrogate ends the string.
//   A multi-byte sequence is gathered across beats and gives no output
//   until its last byte arrives; the byte that completes it is decoded in
//   the cycle of acceptance and its characters are registered.
//   The first character of a byte shows in the cycle after the byte is
//   accepted. Throughput: one output character per cycle while the
//   receiver is ready; a byte that passes through gives one character, an
//   escaped code point three characters per UTF-8 byte. The output
//   serialiser sets the pace; the next byte is taken in the cycle the
//   last character of the previous one leaves.
//   When the receiver stalls, the current character holds and input stops
//   once the serialiser is full. Reset empties the serialiser and clears
//   the sequence and surrogate state; no clearing pass is needed.
`default_nettype none

module utf8_percent_escape (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// Slave side. tdata: [7:0] in_byte. tlast: in_last.
	input  wire logic       in_tvalid,
	output logic            in_tready,
	input  wire logic [7:0] in_tdata,
	input  wire logic       in_tlast,
	// Master side. tdata: [7:0] out_char. tlast: out_last. tuser: [0] uri_error.
	output logic            out_tvalid,
	input  wire logic       out_tready,
	output logic [7:0]      out_tdata,
	output logic            out_tlast,
	output logic            out_tuser
);

	// Sequence and surrogate state
	logic [7:0] bytes_q [3];
	logic [1:0] count_q;
	logic [1:0] need_q;
	logic       pend_q;
	logic [9:0] sbits_q;

	// Serialiser stage
	upe_pkg::cp_units_t cps_s1 [upe_pkg::CP_SLOTS];
	logic [1:0] ncp_s1;
	logic       last_s1;
	logic       err_s1;
	logic       valid_s1;
	logic [1:0] cpi_q;
	logic [1:0] ui_q;
	logic [1:0] ph_q;

	// Decode signals
	logic [7:0]         seq_w [4];
	logic [2:0]         n_w;
	logic [2:0]         total_w;
	logic               accept;
	logic               dec_w;
	logic               complete_w;
	upe_pkg::cp_t       cp_w [upe_pkg::CP_SLOTS];
	logic [1:0]         ncp_w;
	upe_pkg::cp_units_t cu_w [upe_pkg::CP_SLOTS];
	logic               err_w;
	logic               emit_w;

	// Serialiser signals
	upe_pkg::cp_units_t cur_cp;
	upe_pkg::unit_t     cur_unit;
	logic               char_end;
	logic               fin;
	logic [7:0]         cur_char;

	// Sequence length from the lead byte
	function automatic logic [2:0] seq_len(logic [7:0] b0);
		if (b0[7:5] == 3'b110) begin
			return 3'd2;
		end else if (b0[7:4] == 4'b1110) begin
			return 3'd3;
		end else if (b0[7:3] == 5'b11110) begin
			return 3'd4;
		end
		return 3'd1;
	endfunction

	// Characters that pass through unescaped
	function automatic logic passes(logic [6:0] c);
		return c inside {[7'h41:7'h5A], [7'h61:7'h7A], [7'h30:7'h39],
			7'h2D, 7'h5F, 7'h2E, 7'h7E, 7'h21, 7'h27, 7'h28, 7'h29, 7'h2A};
	endfunction

	// Escape one code point, joining a waiting high surrogate if given
	function automatic upe_pkg::cp_units_t make_units(upe_pkg::cp_t c, logic pend,
			logic [9:0] sb);
		upe_pkg::cp_units_t r;
		upe_pkg::cp_t       v;
		r = '0;
		v = upe_pkg::SUPP_BASE + {1'b0, sb, c[9:0]};
		if (pend) begin
			r.cnt  = 3'd4;
			r.u[0] = '{pct: 1'b1, val: 8'hF0 | {5'b0, v[20:18]}};
			r.u[1] = '{pct: 1'b1, val: 8'h80 | {2'b0, v[17:12]}};
			r.u[2] = '{pct: 1'b1, val: 8'h80 | {2'b0, v[11:6]}};
			r.u[3] = '{pct: 1'b1, val: 8'h80 | {2'b0, v[5:0]}};
		end else if (c < 21'h80) begin
			r.cnt  = 3'd1;
			r.u[0] = '{pct: !passes(c[6:0]), val: c[7:0]};
		end else if (c < 21'h800) begin
			r.cnt  = 3'd2;
			r.u[0] = '{pct: 1'b1, val: 8'hC0 | {3'b0, c[10:6]}};
			r.u[1] = '{pct: 1'b1, val: 8'h80 | {2'b0, c[5:0]}};
		end else if (c inside {[upe_pkg::SURR_LO:upe_pkg::SURR_HI]}) begin
			r.surr = 1'b1;
		end else if (c < upe_pkg::SUPP_BASE) begin
			r.cnt  = 3'd3;
			r.u[0] = '{pct: 1'b1, val: 8'hE0 | {4'b0, c[15:12]}};
			r.u[1] = '{pct: 1'b1, val: 8'h80 | {2'b0, c[11:6]}};
			r.u[2] = '{pct: 1'b1, val: 8'h80 | {2'b0, c[5:0]}};
		end else begin
			r.cnt  = 3'd4;
			r.u[0] = '{pct: 1'b1, val: 8'hF0 | {5'b0, c[20:18]}};
			r.u[1] = '{pct: 1'b1, val: 8'h80 | {2'b0, c[17:12]}};
			r.u[2] = '{pct: 1'b1, val: 8'h80 | {2'b0, c[11:6]}};
			r.u[3] = '{pct: 1'b1, val: 8'h80 | {2'b0, c[5:0]}};
		end
		return r;
	endfunction

	// Line up held bytes with the new byte
	always_comb begin
		seq_w[0] = (count_q == 2'd0) ? in_tdata : bytes_q[0];
		seq_w[1] = (count_q == 2'd1) ? in_tdata : ((count_q > 2'd1) ? bytes_q[1] : 8'h00);
		seq_w[2] = (count_q == 2'd2) ? in_tdata : ((count_q == 2'd3) ? bytes_q[2] : 8'h00);
		seq_w[3] = (count_q == 2'd3) ? in_tdata : 8'h00;
		n_w      = {1'b0, count_q} + 3'd1;
		total_w  = (count_q != 2'd0) ? ({1'b0, need_q} + 3'd1) : seq_len(seq_w[0]);
	end

	assign complete_w = (n_w >= total_w);
	assign dec_w      = in_tlast || complete_w;

	// Split into code points: a whole sequence, or a cut-short run
	always_comb begin
		cp_w[0] = {13'b0, seq_w[0]};
		cp_w[1] = {13'b0, seq_w[1]};
		cp_w[2] = {13'b0, seq_w[2]};
		ncp_w   = 2'd1;
		if (complete_w) begin
			case (total_w)
				3'd2: cp_w[0] = {10'b0, seq_w[0][4:0], seq_w[1][5:0]};
				3'd3: cp_w[0] = {5'b0, seq_w[0][3:0], seq_w[1][5:0], seq_w[2][5:0]};
				3'd4: cp_w[0] = {seq_w[0][2:0], seq_w[1][5:0], seq_w[2][5:0],
					seq_w[3][5:0]};
				default: cp_w[0] = {13'b0, seq_w[0]};
			endcase
		end else if (n_w == 3'd2) begin
			ncp_w = 2'd2;
		end else if (n_w == 3'd3) begin
			if (seq_w[1][7:5] == 3'b110) begin
				cp_w[1] = {10'b0, seq_w[1][4:0], seq_w[2][5:0]};
				ncp_w   = 2'd2;
			end else begin
				ncp_w = 2'd3;
			end
		end
	end

	// Only the first code point of a step can meet a waiting surrogate
	always_comb begin
		cu_w[0] = make_units(cp_w[0], pend_q, sbits_q);
		cu_w[1] = make_units(cp_w[1], 1'b0, 10'd0);
		cu_w[2] = make_units(cp_w[2], 1'b0, 10'd0);
	end

	assign err_w  = in_tlast && !pend_q && cu_w[0].surr;
	assign emit_w = dec_w && (err_w || (cu_w[0].cnt != 3'd0));

	// Serialiser view of the current unit
	always_comb begin
		case (cpi_q)
			2'd1:    cur_cp = cps_s1[1];
			2'd2:    cur_cp = cps_s1[2];
			default: cur_cp = cps_s1[0];
		endcase
		cur_unit = cur_cp.u[ui_q];
		char_end = !cur_unit.pct || (ph_q == 2'd2);
		fin      = err_s1 || (char_end && ((3'({1'b0, ui_q}) + 3'd1) == cur_cp.cnt)
			&& ((cpi_q + 2'd1) == ncp_s1));
		case (ph_q)
			2'd0:    cur_char = cur_unit.pct ? upe_pkg::PCT_CHAR : cur_unit.val;
			2'd1:    cur_char = upe_pkg::hex_char(cur_unit.val[7:4]);
			default: cur_char = upe_pkg::hex_char(cur_unit.val[3:0]);
		endcase
	end

	assign in_tready  = !valid_s1 || (out_tready && fin);
	assign accept     = in_tvalid && in_tready;
	assign out_tvalid = valid_s1;
	assign out_tdata  = err_s1 ? upe_pkg::ERR_CHAR : cur_char;
	assign out_tlast  = last_s1 && fin;
	assign out_tuser  = err_s1;

	// Hold a partial sequence, or drop it once decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			need_q  <= 2'd0;
			pend_q  <= 1'b0;
			sbits_q <= 10'd0;
		end else if (accept) begin
			if (!dec_w) begin
				count_q <= n_w[1:0];
				need_q  <= 2'(total_w - 3'd1);
			end else begin
				count_q <= 2'd0;
				need_q  <= 2'd0;
				if (in_tlast || pend_q) begin
					pend_q  <= 1'b0;
					sbits_q <= 10'd0;
				end else if (cu_w[0].surr) begin
					pend_q  <= 1'b1;
					sbits_q <= cp_w[0][9:0];
				end
			end
		end
	end

	// Partial sequence bytes
	always_ff @(posedge clk) begin
		if (accept && !dec_w) begin
			bytes_q[0] <= seq_w[0];
			bytes_q[1] <= seq_w[1];
			bytes_q[2] <= seq_w[2];
		end
	end

	// Load the units of a decoded byte
	always_ff @(posedge clk) begin
		if (accept && emit_w) begin
			cps_s1[0] <= cu_w[0];
			cps_s1[1] <= cu_w[1];
			cps_s1[2] <= cu_w[2];
			ncp_s1    <= ncp_w;
			last_s1   <= in_tlast;
			err_s1    <= err_w;
		end
	end

	// Advance through units and characters on each output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cpi_q    <= 2'd0;
			ui_q     <= 2'd0;
			ph_q     <= 2'd0;
		end else if (accept && emit_w) begin
			valid_s1 <= 1'b1;
			cpi_q    <= 2'd0;
			ui_q     <= 2'd0;
			ph_q     <= 2'd0;
		end else if (valid_s1 && out_tready) begin
			if (fin) begin
				valid_s1 <= 1'b0;
			end else if (char_end) begin
				ph_q <= 2'd0;
				if ((3'({1'b0, ui_q}) + 3'd1) == cur_cp.cnt) begin
					cpi_q <= cpi_q + 2'd1;
					ui_q  <= 2'd0;
				end else begin
					ui_q <= ui_q + 2'd1;
				end
			end else begin
				ph_q <= ph_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/upe_checker.sv
// Port-level checker for utf8_percent_escape, bound to the top level.
// Depends on upe_pkg for the escape and error characters.
`default_nettype none

module upe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_tready,
	input wire logic       out_tvalid,
	input wire logic       out_tready,
	input wire logic [7:0] out_tdata,
	input wire logic       out_tlast,
	input wire logic       out_tuser
);

	logic out_beat;

	assign out_beat = out_tvalid && out_tready;

	// A stalled beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
			&& $stable(out_tlast) && $stable(out_tuser))
		else $error("stalled output beat changed");

	// Input only stops while output is waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_tready |-> out_tvalid)
		else $error("input stalled with no output pending");

	// The error beat is a lone zero character ending the string
	assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid && out_tuser |-> out_tlast && (out_tdata == upe_pkg::ERR_CHAR))
		else $error("malformed error beat");

	// A percent sign is followed at once by a hex digit, never the end
	assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && !out_tuser && (out_tdata == upe_pkg::PCT_CHAR)
			|-> !out_tlast ##1 out_tvalid && !out_tuser
			&& (((out_tdata >= 8'h30) && (out_tdata <= 8'h39))
			|| ((out_tdata >= 8'h41) && (out_tdata <= 8'h46))))
		else $error("percent sign not followed by a hex digit");

endmodule

bind utf8_percent_escape upe_checker u_upe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_tready  (in_tready),
	.out_tvalid (out_tvalid),
	.out_tready (out_tready),
	.out_tdata  (out_tdata),
	.out_tlast  (out_tlast),
	.out_tuser  (out_tuser)
);

`default_nettype wire

// File: verif/utf8_percent_escape_tb.sv
// Self-checking testbench for utf8_percent_escape: drives UTF-8 strings on the
// slave side and checks the escaped text on the master side against a predictor.
// Depends on upe_pkg for the fixed characters and the code point limits.
`timescale 1ns / 1ps

module utf8_percent_escape_tb;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_PER_BEAT = 24;
	localparam int RAND_PER_PHASE = 20;
	localparam logic [127:0] HEX_TEXT = "0123456789ABCDEF";

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       err;
	} esc_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_tvalid = 1'b0;
	logic       in_tready;
	logic [7:0] in_tdata = 8'h00;   // [7:0] in_byte
	logic       in_tlast = 1'b0;
	logic       out_tvalid;
	logic       out_tready = 1'b0;
	logic [7:0] out_tdata;          // [7:0] out_char
	logic       out_tlast;
	logic       out_tuser;          // [0] uri_error

	utf8_percent_escape u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_tvalid  (in_tvalid),
		.in_tready  (in_tready),
		.in_tdata   (in_tdata),
		.in_tlast   (in_tlast),
		.out_tvalid (out_tvalid),
		.out_tready (out_tready),
		.out_tdata  (out_tdata),
		.out_tlast  (out_tlast),
		.out_tuser  (out_tuser)
	);

	always #1 clk = ~clk;

	// Stimulus and expectation stores
	in_beat_t  byte_q[$];
	esc_char_t escaped_q[$];
	logic [7:0] str_bytes[$];
	in_beat_t  next_beat;
	esc_char_t got_char;
	esc_char_t want_char;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_reqs = 0;
	int holds_done = 0;
	int hold_left = 0;
	int mismatches = 0;
	int items_queued = 0;
	int beats_in = 0;
	int beats_out = 0;
	int strings_done = 0;
	int error_beats = 0;
	int cycles = 0;

	// Predictor state: held sequence and pending high surrogate
	logic [7:0] held_bytes [3];
	logic [1:0] held_cnt = 2'd0;
	logic [1:0] held_need = 2'd0;
	logic       sur_pending = 1'b0;
	logic [9:0] sur_bits = 10'd0;
	logic [7:0] step_bytes [4];
	logic [7:0] step_chars[$];

	function automatic logic [7:0] hex_digit(logic [3:0] n);
		return HEX_TEXT[127 - 8 * n -: 8];
	endfunction

	function automatic bit is_plain(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
			(c >= "0" && c <= "9") || c == "-" || c == "_" || c == "." ||
			c == "~" || c == "!" || c == "'" || c == "(" || c == ")" ||
			c == "*";
	endfunction

	function automatic int lead_len(logic [7:0] b);
		if (b[7:5] == 3'b110) return 2;
		if (b[7:4] == 4'b1110) return 3;
		if (b[7:3] == 5'b11110) return 4;
		return 1;
	endfunction

	task automatic emit_char(input logic [7:0] c);
		if (step_chars.size() < MAX_PER_BEAT) step_chars.push_back(c);
	endtask

	task automatic emit_pct(input logic [7:0] b);
		emit_char(upe_pkg::PCT_CHAR);
		emit_char(hex_digit(b[7:4]));
		emit_char(hex_digit(b[3:0]));
	endtask

	task automatic emit_four(input upe_pkg::cp_t c);
		emit_pct({5'b11110, c[20:18]});
		emit_pct({2'b10, c[17:12]});
		emit_pct({2'b10, c[11:6]});
		emit_pct({2'b10, c[5:0]});
	endtask

	// Escape one decoded code point, pairing a pending high surrogate blindly
	task automatic escape_code_point(input upe_pkg::cp_t c);
		if (sur_pending) begin
			emit_four(upe_pkg::SUPP_BASE + {1'b0, sur_bits, c[9:0]});
			sur_pending = 1'b0;
			sur_bits = 10'd0;
		end else if (c < 21'h80) begin
			if (is_plain(c[7:0])) emit_char(c[7:0]);
			else emit_pct(c[7:0]);
		end else if (c < 21'h800) begin
			emit_pct({3'b110, c[10:6]});
			emit_pct({2'b10, c[5:0]});
		end else if (c >= upe_pkg::SURR_LO && c <= upe_pkg::SURR_HI) begin
			sur_pending = 1'b1;
			sur_bits = c[9:0];
		end else if (c < 21'h10000) begin
			emit_pct({4'b1110, c[15:12]});
			emit_pct({2'b10, c[11:6]});
			emit_pct({2'b10, c[5:0]});
		end else begin
			emit_four(c);
		end
	endtask

	// Walk step_bytes[0..n); a lead byte whose sequence runs past n stands alone
	task automatic decode_step(input int n);
		int i;
		int len;
		upe_pkg::cp_t c;
		logic [7:0] b0;
		i = 0;
		while (i < n) begin
			b0 = step_bytes[i];
			if (b0 < 8'h80) begin
				c = {13'd0, b0};
				len = 1;
			end else if (b0[7:5] == 3'b110 && i + 1 < n) begin
				c = {10'd0, b0[4:0], step_bytes[i+1][5:0]};
				len = 2;
			end else if (b0[7:4] == 4'b1110 && i + 2 < n) begin
				c = {5'd0, b0[3:0], step_bytes[i+1][5:0], step_bytes[i+2][5:0]};
				len = 3;
			end else if (b0[7:3] == 5'b11110 && i + 3 < n) begin
				c = {b0[2:0], step_bytes[i+1][5:0], step_bytes[i+2][5:0],
					step_bytes[i+3][5:0]};
				len = 4;
			end else begin
				c = {13'd0, b0};
				len = 1;
			end
			i += len;
			escape_code_point(c);
		end
	endtask

	// Work out the escaped characters caused by one accepted input beat
	task automatic predict_escape(input logic [7:0] b, input logic last);
		int n;
		int total;
		esc_char_t e;
		n = 0;
		for (int i = 0; i < held_cnt; i++) begin
			step_bytes[n] = held_bytes[i];
			n++;
		end
		step_bytes[n] = b;
		n++;
		total = (n > 1) ? held_need + 1 : lead_len(step_bytes[0]);
		step_chars.delete();
		if (!last) begin
			if (n < total) begin
				// Hold the unfinished sequence
				for (int i = 0; i < n; i++) held_bytes[i] = step_bytes[i];
				held_cnt = n[1:0];
				held_need = total[1:0] - 2'd1;
				return;
			end
			held_cnt = 2'd0;
			held_need = 2'd0;
			decode_step(n);
			for (int k = 0; k < step_chars.size(); k++) begin
				e.ch = step_chars[k];
				e.last = 1'b0;
				e.err = 1'b0;
				escaped_q.push_back(e);
			end
		end else begin
			decode_step(n);
			if (sur_pending) begin
				e.ch = upe_pkg::ERR_CHAR;
				e.last = 1'b1;
				e.err = 1'b1;
				escaped_q.push_back(e);
			end else begin
				for (int k = 0; k < step_chars.size(); k++) begin
					e.ch = step_chars[k];
					e.last = (k == step_chars.size() - 1);
					e.err = 1'b0;
					escaped_q.push_back(e);
				end
			end
			held_cnt = 2'd0;
			held_need = 2'd0;
			sur_pending = 1'b0;
			sur_bits = 10'd0;
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < 40)
			$display("MISMATCH at output beat %0d: %s got 0x%0h, expected 0x%0h",
				beats_out, what, got, want);
		mismatches++;
	endtask

	task automatic add_byte(input logic [7:0] b, input logic last);
		in_beat_t t;
		t.b = b;
		t.last = last;
		byte_q.push_back(t);
		items_queued++;
	endtask

	// Continuation byte, now and then replaced by any byte at all
	function automatic logic [7:0] cont_byte(logic [5:0] bits);
		if ($urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
		return {2'b10, bits};
	endfunction

	task automatic add_utf8(input upe_pkg::cp_t c, input int len);
		case (len)
			1: str_bytes.push_back({1'b0, c[6:0]});
			2: begin
				str_bytes.push_back({3'b110, c[10:6]});
				str_bytes.push_back(cont_byte(c[5:0]));
			end
			3: begin
				str_bytes.push_back({4'b1110, c[15:12]});
				str_bytes.push_back(cont_byte(c[11:6]));
				str_bytes.push_back(cont_byte(c[5:0]));
			end
			default: begin
				str_bytes.push_back({5'b11110, c[20:18]});
				str_bytes.push_back(cont_byte(c[17:12]));
				str_bytes.push_back(cont_byte(c[11:6]));
				str_bytes.push_back(cont_byte(c[5:0]));
			end
		endcase
	endtask

	// One string of random code points, mostly well formed, some noise
	task automatic add_random_string();
		int nchars;
		int kind;
		int len;
		int m;
		str_bytes.delete();
		nchars = $urandom_range(1, 6);
		for (int i = 0; i < nchars; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				add_utf8(upe_pkg::cp_t'($urandom_range(0, 127)), 1);
			end else if (kind < 55) begin
				add_utf8(upe_pkg::cp_t'($urandom_range(0, 21'h7FF)), 2);
			end else if (kind < 70) begin
				add_utf8(upe_pkg::cp_t'($urandom_range(0, 21'hFFFF)), 3);
			end else if (kind < 80) begin
				add_utf8(upe_pkg::cp_t'($urandom_range(upe_pkg::SURR_LO,
					upe_pkg::SURR_HI)), 3);
			end else if (kind < 88) begin
				add_utf8(upe_pkg::cp_t'($urandom_range(21'h10000, 21'h1FFFFF)), 4);
			end else if (kind < 94) begin
				str_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				// Broken sequence: lead byte with too few continuation bytes
				len = $urandom_range(2, 4);
				case (len)
					2: str_bytes.push_back({3'b110, 5'($urandom_range(0, 31))});
					3: str_bytes.push_back({4'b1110, 4'($urandom_range(0, 15))});
					default: str_bytes.push_back({5'b11110, 3'($urandom_range(0, 7))});
				endcase
				m = $urandom_range(0, len - 2);
				for (int k = 0; k < m; k++)
					str_bytes.push_back({2'b10, 6'($urandom_range(0, 63))});
			end
		end
		for (int k = 0; k < str_bytes.size(); k++)
			add_byte(str_bytes[k], k == str_bytes.size() - 1);
	endtask

	task automatic add_random_strings(input int count);
		int target;
		target = items_queued + count;
		while (items_queued < target) add_random_string();
	endtask

	task automatic add_directed();
		// Plain characters, escaped ASCII and the zero byte
		add_byte("A", 1'b0); add_byte("~", 1'b0); add_byte("%", 1'b0);
		add_byte(8'h00, 1'b0);
		// Invalid lead bytes stand as their own value
		add_byte(8'hFF, 1'b0); add_byte(8'h80, 1'b0);
		// Two-, three- and four-byte forms
		add_byte(8'hC3, 1'b0); add_byte(8'hA9, 1'b0);
		add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'hAC, 1'b0);
		add_byte(8'hF0, 1'b0); add_byte(8'h9F, 1'b0); add_byte(8'h98, 1'b0);
		add_byte(8'h80, 1'b1);
		// Overlong form of an ASCII letter
		add_byte(8'hC1, 1'b0); add_byte(8'h81, 1'b1);
		// High surrogate combined with the next code point
		add_byte(8'hED, 1'b0); add_byte(8'hA0, 1'b0); add_byte(8'h80, 1'b0);
		add_byte("A", 1'b1);
		// High surrogate ending the string
		add_byte(8'hED, 1'b0); add_byte(8'hA0, 1'b0); add_byte(8'h80, 1'b1);
		// Sequences cut short by the end of the string
		add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b1);
		add_byte(8'hF0, 1'b0); add_byte("A", 1'b0); add_byte("B", 1'b1);
	endtask

	task automatic wait_drained();
		while (byte_q.size() != 0 || in_tvalid || escaped_q.size() != 0)
			@(posedge clk);
	endtask

	// Sender: predict on acceptance, then offer the next queued beat or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tvalid <= 1'b0;
			in_tdata <= 8'h00;
			in_tlast <= 1'b0;
		end else begin
			if (in_tvalid && in_tready) begin
				predict_escape(in_tdata, in_tlast);
				beats_in++;
				if (in_tlast) strings_done++;
			end
			if (!in_tvalid || in_tready) begin
				if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_beat = byte_q.pop_front();
					in_tvalid <= 1'b1;
					in_tdata <= next_beat.b;
					in_tlast <= next_beat.last;
				end else begin
					in_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, started on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_done != hold_reqs) begin
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	// Receiver: check each accepted beat against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_tready <= 1'b0;
		end else begin
			if (out_tvalid && out_tready) begin
				got_char.ch = out_tdata;
				got_char.last = out_tlast;
				got_char.err = out_tuser;
				if (got_char.err) error_beats++;
				if (escaped_q.size() == 0) begin
					report_mismatch("beat with nothing expected, char", got_char.ch, 0);
				end else begin
					want_char = escaped_q.pop_front();
					if (got_char.ch !== want_char.ch)
						report_mismatch("out_char", got_char.ch, want_char.ch);
					if (got_char.last !== want_char.last)
						report_mismatch("out_last", got_char.last, want_char.last);
					if (got_char.err !== want_char.err)
						report_mismatch("uri_error", got_char.err, want_char.err);
				end
				beats_out++;
			end
			out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d characters still expected",
				cycles, escaped_q.size());
			$display("utf8_percent_escape_tb failed");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings, then random ones, with no idling
		add_directed();
		add_random_strings(RAND_PER_PHASE);
		wait_drained();

		// Sender idles
		send_idle_pct <= 48;
		stall_pct <= 0;
		add_random_strings(RAND_PER_PHASE);
		wait_drained();

		// Receiver stalls
		send_idle_pct <= 0;
		stall_pct <= 48;
		add_random_strings(RAND_PER_PHASE);
		wait_drained();

		// Both sides idle
		send_idle_pct <= 17;
		stall_pct <= 17;
		add_random_strings(RAND_PER_PHASE);
		wait_drained();

		// Receiver holds off while the sender keeps offering
		send_idle_pct <= 0;
		stall_pct <= 0;
		hold_reqs <= hold_reqs + 1;
		add_random_strings(RAND_PER_PHASE);
		wait_drained();

		repeat (MAX_PER_BEAT + 8) @(posedge clk);
		if (escaped_q.size() != 0)
			report_mismatch("characters never delivered, count", 0, escaped_q.size());

		$display("Sent %0d bytes in %0d strings, received %0d characters (%0d error beats),",
			beats_in, strings_done, beats_out, error_beats);
		$display("over idle-free, sender-idle, receiver-stall, mixed and hold-off phases.");
		if (mismatches == 0) begin
			$display("utf8_percent_escape_tb passed");
		end else begin
			$display("utf8_percent_escape_tb failed");
		end
		$finish;
	end

endmodule
